>>> rtl/tid_pkg.sv
// ----------------------------------------------------------------------------
// tid_pkg
// Shared types and class codes for the Thumb halfword decoder.
// ----------------------------------------------------------------------------
package tid_pkg;

    localparam logic [5:0] CLS_MOV_SHIFT     = 6'd0;
    localparam logic [5:0] CLS_ADD_REG       = 6'd1;
    localparam logic [5:0] CLS_SUB_REG       = 6'd2;
    localparam logic [5:0] CLS_MOV_IMM       = 6'd3;
    localparam logic [5:0] CLS_ALU_OP        = 6'd7;
    localparam logic [5:0] CLS_HI_REG_OP     = 6'd8;
    localparam logic [5:0] CLS_PC_REL_LOAD   = 6'd9;
    localparam logic [5:0] CLS_STORE_REG_OFS = 6'd10;
    localparam logic [5:0] CLS_LOAD_REG_OFS  = 6'd11;
    localparam logic [5:0] CLS_SIGN_HALF     = 6'd12;
    localparam logic [5:0] CLS_STORE_IMM_OFS = 6'd13;
    localparam logic [5:0] CLS_LOAD_IMM_OFS  = 6'd14;
    localparam logic [5:0] CLS_STORE_HALF    = 6'd15;
    localparam logic [5:0] CLS_LOAD_HALF     = 6'd16;
    localparam logic [5:0] CLS_SP_REL_STORE  = 6'd17;
    localparam logic [5:0] CLS_SP_REL_LOAD   = 6'd18;
    localparam logic [5:0] CLS_LOAD_ADDRESS  = 6'd19;
    localparam logic [5:0] CLS_OFFSET_SP     = 6'd20;
    localparam logic [5:0] CLS_PUSH          = 6'd21;
    localparam logic [5:0] CLS_POP           = 6'd22;
    localparam logic [5:0] CLS_STORE_MULTI   = 6'd23;
    localparam logic [5:0] CLS_LOAD_MULTI    = 6'd24;
    localparam logic [5:0] CLS_SXTH          = 6'd25;
    localparam logic [5:0] CLS_BRANCH        = 6'd29;
    localparam logic [5:0] CLS_COND_BRANCH   = 6'd30;
    localparam logic [5:0] CLS_LONG_PREFIX   = 6'd31;
    localparam logic [5:0] CLS_LONG_BL       = 6'd32;
    localparam logic [5:0] CLS_LONG_BLX      = 6'd33;
    localparam logic [5:0] CLS_UNDEF         = 6'd34;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam logic [3:0] COND_SWI   = 4'hF;
    localparam logic [3:0] COND_NEVER = 4'hE;

    localparam logic [3:0] MISC_ADJ_SP = 4'h0;
    localparam logic [3:0] MISC_EXTEND = 4'h2;
    localparam logic [3:0] MISC_PUSH   = 4'h4;
    localparam logic [3:0] MISC_PUSH_L = 4'h5;
    localparam logic [3:0] MISC_POP    = 4'hC;
    localparam logic [3:0] MISC_POP_P  = 4'hD;

    localparam logic [1:0] SHIFT_LSL   = 2'd0;
    localparam logic [1:0] SHIFT_ADDSUB = 2'd3;
    localparam logic [1:0] SH_OP_STRH  = 2'd0;
    localparam logic [1:0] SH_OP_LDSB  = 2'd1;

    typedef struct packed {
        logic [5:0]  instr_class;
        logic [3:0]  sub_op;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic [3:0]  base_reg;
        logic [2:0]  offset_reg;
        logic [9:0]  immediate;
        logic [8:0]  reg_mask;
        logic        is_load;
        logic        is_byte_or_imm;
        logic        exchange;
        logic [31:0] target;
    } t_tid_result;

endpackage

>>> rtl/tid_if.sv
// ----------------------------------------------------------------------------
// tid_req_if / tid_rsp_if
// Valid/ready channels for decoder requests and decoded results.
// ----------------------------------------------------------------------------
interface tid_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] halfword;
    logic [15:0] next_halfword;
    logic [31:0] pc_value;

    modport source (output valid, output halfword, output next_halfword,
                    output pc_value, input ready);
    modport sink   (input valid, input halfword, input next_halfword,
                    input pc_value, output ready);
endinterface

interface tid_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  instr_class;
    logic [3:0]  sub_op;
    logic [3:0]  dest_reg;
    logic [3:0]  src_reg;
    logic [3:0]  base_reg;
    logic [2:0]  offset_reg;
    logic [9:0]  immediate;
    logic [8:0]  reg_mask;
    logic        is_load;
    logic        is_byte_or_imm;
    logic        exchange;
    logic [31:0] target;

    modport source (output valid, output instr_class, output sub_op, output dest_reg,
                    output src_reg, output base_reg, output offset_reg, output immediate,
                    output reg_mask, output is_load, output is_byte_or_imm,
                    output exchange, output target, input ready);
    modport sink   (input valid, input instr_class, input sub_op, input dest_reg,
                    input src_reg, input base_reg, input offset_reg, input immediate,
                    input reg_mask, input is_load, input is_byte_or_imm,
                    input exchange, input target, output ready);
endinterface

>>> rtl/tid_decode.sv
// ----------------------------------------------------------------------------
// tid_decode
// Combinational field extraction and target arithmetic for one halfword.
// ----------------------------------------------------------------------------
module tid_decode
    import tid_pkg::*;
(
    input  logic [15:0] i_halfword,
    input  logic [15:0] i_next_halfword,
    input  logic [31:0] i_pc_value,
    output t_tid_result o_result
);

    logic [15:0] h;
    logic [4:0]  top5;
    logic [3:0]  top4;
    logic [2:0]  top3;
    logic [5:0]  top6;
    logic [3:0]  lo3;
    logic [3:0]  mid3;
    logic [3:0]  r8;
    logic [31:0] pc_word;
    logic [9:0]  imm8_x4;
    logic [31:0] long_hi;
    logic [31:0] long_sum;
    logic [4:0]  shift_amt;

    assign h         = i_halfword;
    assign top5      = h[15:11];
    assign top4      = h[15:12];
    assign top3      = h[15:13];
    assign top6      = h[15:10];
    assign lo3       = {1'b0, h[2:0]};
    assign mid3      = {1'b0, h[5:3]};
    assign r8        = {1'b0, h[10:8]};
    assign pc_word   = {i_pc_value[31:2], 2'b00};
    assign imm8_x4   = {h[7:0], 2'b00};
    assign shift_amt = h[10:6];
    assign long_hi   = {{9{h[10]}}, h[10:0], 12'b0};
    assign long_sum  = i_pc_value + long_hi + {20'b0, i_next_halfword[10:0], 1'b0};

    always_comb begin
        o_result             = '0;
        o_result.instr_class = CLS_UNDEF;
        if (top5[4:2] == 3'b001) begin
            o_result.instr_class = CLS_MOV_IMM + {4'b0, h[12:11]};
            o_result.sub_op      = {2'b0, h[12:11]};
            o_result.dest_reg    = r8;
            o_result.immediate   = {2'b0, h[7:0]};
        end else if (top5 == 5'h09) begin
            o_result.instr_class = CLS_PC_REL_LOAD;
            o_result.dest_reg    = r8;
            o_result.base_reg    = REG_PC;
            o_result.is_load     = 1'b1;
            o_result.immediate   = imm8_x4;
            o_result.target      = pc_word + {22'b0, imm8_x4};
        end else if (top5[4:1] == 4'b1000) begin
            o_result.instr_class = h[11] ? CLS_LOAD_HALF : CLS_STORE_HALF;
            o_result.dest_reg    = lo3;
            o_result.base_reg    = mid3;
            o_result.immediate   = {4'b0, h[10:6], 1'b0};
            o_result.is_load     = h[11];
        end else if (top5[4:1] == 4'b1001) begin
            o_result.instr_class = h[11] ? CLS_SP_REL_LOAD : CLS_SP_REL_STORE;
            o_result.dest_reg    = r8;
            o_result.base_reg    = REG_SP;
            o_result.immediate   = imm8_x4;
            o_result.is_load     = h[11];
        end else if (top5[4:1] == 4'b1100) begin
            o_result.instr_class = h[11] ? CLS_LOAD_MULTI : CLS_STORE_MULTI;
            o_result.base_reg    = r8;
            o_result.reg_mask    = {1'b0, h[7:0]};
            o_result.is_load     = h[11];
        end else if (top5 == 5'h1C) begin
            o_result.instr_class = CLS_BRANCH;
            o_result.target      = i_pc_value + {{20{h[10]}}, h[10:0], 1'b0};
        end else if (top5 == 5'h1D) begin
            // odd suffix offset is not a valid BLX
            if (!h[0]) begin
                o_result.instr_class = CLS_LONG_BLX;
                o_result.exchange    = 1'b1;
            end
        end else if (top3 == 3'b000) begin
            o_result.dest_reg = lo3;
            o_result.src_reg  = mid3;
            if (h[12:11] != SHIFT_ADDSUB) begin
                o_result.instr_class = CLS_MOV_SHIFT;
                o_result.sub_op      = {2'b0, h[12:11]};
                // zero count means 32 for the right shifts
                if (h[12:11] != SHIFT_LSL && shift_amt == 5'd0) begin
                    o_result.immediate = 10'd32;
                end else begin
                    o_result.immediate = {5'b0, shift_amt};
                end
            end else begin
                o_result.instr_class    = h[9] ? CLS_SUB_REG : CLS_ADD_REG;
                o_result.is_byte_or_imm = h[10];
                if (h[10]) begin
                    o_result.immediate = {7'b0, h[8:6]};
                end else begin
                    o_result.offset_reg = h[8:6];
                end
            end
        end else if (top6 == 6'h10) begin
            o_result.instr_class = CLS_ALU_OP;
            o_result.sub_op      = h[9:6];
            o_result.dest_reg    = lo3;
            o_result.src_reg     = mid3;
        end else if (top6 == 6'h11) begin
            o_result.instr_class = CLS_HI_REG_OP;
            o_result.sub_op      = {2'b0, h[9:8]};
            o_result.dest_reg    = {h[7], h[2:0]};
            o_result.src_reg     = {h[6], h[5:3]};
        end else if (top4 == 4'h5) begin
            o_result.dest_reg   = lo3;
            o_result.base_reg   = mid3;
            o_result.offset_reg = h[8:6];
            if (!h[9]) begin
                o_result.is_load        = h[11];
                o_result.is_byte_or_imm = h[10];
                o_result.instr_class    = h[11] ? CLS_LOAD_REG_OFS : CLS_STORE_REG_OFS;
            end else begin
                o_result.instr_class    = CLS_SIGN_HALF;
                o_result.sub_op         = {2'b0, h[11:10]};
                o_result.is_load        = (h[11:10] != SH_OP_STRH);
                o_result.is_byte_or_imm = (h[11:10] == SH_OP_LDSB);
            end
        end else if (top3 == 3'b011) begin
            o_result.is_load        = h[11];
            o_result.is_byte_or_imm = h[12];
            o_result.instr_class    = h[11] ? CLS_LOAD_IMM_OFS : CLS_STORE_IMM_OFS;
            o_result.dest_reg       = lo3;
            o_result.base_reg       = mid3;
            // word access scales the offset by four
            o_result.immediate      = h[12] ? {5'b0, h[10:6]} : {3'b0, h[10:6], 2'b00};
        end else if (top4 == 4'hA) begin
            o_result.instr_class = CLS_LOAD_ADDRESS;
            o_result.dest_reg    = r8;
            o_result.immediate   = imm8_x4;
            if (h[11]) begin
                o_result.base_reg = REG_SP;
            end else begin
                o_result.base_reg = REG_PC;
                o_result.target   = pc_word + {22'b0, imm8_x4};
            end
        end else if (top4 == 4'hB) begin
            unique case (h[11:8])
                MISC_ADJ_SP: begin
                    o_result.instr_class = CLS_OFFSET_SP;
                    o_result.dest_reg    = REG_SP;
                    o_result.base_reg    = REG_SP;
                    o_result.sub_op      = {3'b0, h[7]};
                    o_result.immediate   = {1'b0, h[6:0], 2'b00};
                end
                MISC_EXTEND: begin
                    o_result.sub_op      = {2'b0, h[7:6]};
                    o_result.instr_class = CLS_SXTH + {4'b0, h[7:6]};
                    o_result.dest_reg    = lo3;
                    o_result.src_reg     = mid3;
                end
                MISC_PUSH, MISC_PUSH_L, MISC_POP, MISC_POP_P: begin
                    o_result.is_load     = h[11];
                    o_result.instr_class = h[11] ? CLS_POP : CLS_PUSH;
                    o_result.base_reg    = REG_SP;
                    o_result.reg_mask    = h[8:0];
                end
                default: begin
                    o_result.instr_class = CLS_UNDEF;
                end
            endcase
        end else if (top4 == 4'hD) begin
            if (h[11:8] == COND_SWI) begin
                o_result.instr_class = CLS_COND_BRANCH;
                o_result.sub_op      = COND_SWI;
                o_result.immediate   = {2'b0, h[7:0]};
            end else if (h[11:8] != COND_NEVER) begin
                o_result.instr_class = CLS_COND_BRANCH;
                o_result.sub_op      = h[11:8];
                o_result.target      = i_pc_value + {{23{h[7]}}, h[7:0], 1'b0};
            end
        end else if (top4 == 4'hF) begin
            if (!h[11]) begin
                o_result.instr_class = CLS_LONG_PREFIX;
                o_result.exchange    = !i_next_halfword[12];
                // BLX lands on a word boundary
                o_result.target      = i_next_halfword[12] ? long_sum
                                                           : {long_sum[31:2], 2'b00};
            end else begin
                o_result.instr_class = CLS_LONG_BL;
            end
        end
    end

endmodule

>>> rtl/thumb_instruction_decoder_core.sv
// ----------------------------------------------------------------------------
// thumb_instruction_decoder_core
// Thumb halfword decoder: input register, decode logic, result register.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; the request is captured in the input register
//   and its decoded result in the result register before o_rsp.valid rises.
// Throughput: one request per cycle; each register stage advances when the
//   stage after it is empty or being drained.
// Reset: synchronous, active low; clears both stage valid flags only.
module thumb_instruction_decoder_core
    import tid_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tid_req_if.sink       i_req,
    tid_rsp_if.source     o_rsp
);

    logic        r_in_valid;
    logic [15:0] r_halfword;
    logic [15:0] r_next_halfword;
    logic [31:0] r_pc_value;
    logic        r_out_valid;
    t_tid_result r_res;

    logic        n_in_valid;
    logic        n_out_valid;
    logic        out_advance;
    logic        in_advance;
    t_tid_result dec_res;

    tid_decode u_decode (
        .i_halfword      (r_halfword),
        .i_next_halfword (r_next_halfword),
        .i_pc_value      (r_pc_value),
        .o_result        (dec_res)
    );

    assign out_advance = !r_out_valid || o_rsp.ready;
    assign in_advance  = !r_in_valid || out_advance;
    assign i_req.ready = in_advance;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (in_advance) begin
            n_in_valid = i_req.valid;
        end
        if (out_advance) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers load on advance; no reset needed
    always_ff @(posedge i_clk) begin
        if (in_advance && i_req.valid) begin
            r_halfword      <= i_req.halfword;
            r_next_halfword <= i_req.next_halfword;
            r_pc_value      <= i_req.pc_value;
        end
        if (out_advance && r_in_valid) begin
            r_res <= dec_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.instr_class    = r_res.instr_class;
    assign o_rsp.sub_op         = r_res.sub_op;
    assign o_rsp.dest_reg       = r_res.dest_reg;
    assign o_rsp.src_reg        = r_res.src_reg;
    assign o_rsp.base_reg       = r_res.base_reg;
    assign o_rsp.offset_reg     = r_res.offset_reg;
    assign o_rsp.immediate      = r_res.immediate;
    assign o_rsp.reg_mask       = r_res.reg_mask;
    assign o_rsp.is_load        = r_res.is_load;
    assign o_rsp.is_byte_or_imm = r_res.is_byte_or_imm;
    assign o_rsp.exchange       = r_res.exchange;
    assign o_rsp.target         = r_res.target;

endmodule

>>> rtl/tid_checker.sv
// ----------------------------------------------------------------------------
// tid_checker
// Port-level assertions for the Thumb halfword decoder, bound to the top.
// ----------------------------------------------------------------------------
module tid_checker
    import tid_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [5:0]  i_rsp_class,
    input logic [9:0]  i_rsp_imm,
    input logic [8:0]  i_rsp_list,
    input logic        i_rsp_exchange,
    input logic [31:0] i_rsp_target
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_class) && $stable(i_rsp_target))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    a_undef_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_class == CLS_UNDEF |->
            i_rsp_target == 32'd0 && i_rsp_imm == 10'd0 && i_rsp_list == 9'd0
            && !i_rsp_exchange)
        else $error("undefined instruction carries fields");

    a_exchange_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_exchange |->
            i_rsp_class == CLS_LONG_PREFIX || i_rsp_class == CLS_LONG_BLX)
        else $error("exchange on a non-BLX class");

    a_blx_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_exchange && i_rsp_class == CLS_LONG_PREFIX |->
            i_rsp_target[1:0] == 2'b00)
        else $error("BLX target not word aligned");

endmodule

bind thumb_instruction_decoder_core tid_checker u_tid_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_class    (o_rsp.instr_class),
    .i_rsp_imm      (o_rsp.immediate),
    .i_rsp_list     (o_rsp.reg_mask),
    .i_rsp_exchange (o_rsp.exchange),
    .i_rsp_target   (o_rsp.target)
);
